@@ hdl/hpwr_pkg.sv @@
package hpwr_pkg;

    // Fixed field widths of the block.
    localparam int HP_BITS     = 20;
    localparam int SQ_BITS     = 2 * HP_BITS;
    localparam int SUM_BITS    = 64;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int COEFF_BITS  = 16;
    localparam int WIN_BITS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH = 4;

    // Saturation limits of the filter outputs and of the RMS value.
    localparam logic [HP_BITS-1:0] HP_MAX  = 20'h7FFFF;
    localparam logic [HP_BITS-1:0] HP_MIN  = 20'h80000;
    localparam logic [HP_BITS-1:0] RMS_MAX = 20'hFFFFF;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_COEFF = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_MS    = 1'b1;
    localparam logic [COEFF_BITS-1:0]   COEFF_RESET      = 16'd62259;
    localparam logic [WIN_BITS-1:0]     WINDOW_RESET     = 16'd1000;

    // Sequencer of the filter and accumulation back end.
    typedef enum logic [2:0] {
        B_IDLE,
        B_FILT,
        B_RMS,
        B_WAIT,
        B_FIN
    } back_state_t;

    // Sequencer of the divide and square-root unit.
    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT,
        R_DONE
    } rms_state_t;

endpackage

@@ hdl/hpwr_queue.sv @@
module hpwr_queue import hpwr_pkg::*; #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    // Handshake qualifiers.
    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push into a queue that is not full, without a pop, grows the count by one.
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not grow on push");

endmodule

@@ hdl/hpwr_front.sv @@
module hpwr_front import hpwr_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [SAMPLE_BITS-1:0]   accel_x,
    input  logic [SAMPLE_BITS-1:0]   accel_y,
    input  logic [SAMPLE_BITS-1:0]   accel_z,
    input  logic [TIME_BITS-1:0]     now_ms,
    input  logic [WIN_BITS-1:0]      window_ms,
    input  logic                     q_full,
    output logic                     push,
    output logic [3*SAMPLE_BITS:0]   push_data
);

    logic [TIME_BITS-1:0] window_start_reg;
    logic [TIME_BITS-1:0] elapsed;
    logic                 closes;

    // The wrapping age of the open window decides whether this beat closes it.
    assign elapsed = now_ms - window_start_reg;
    assign closes  = (elapsed >= {{(TIME_BITS-WIN_BITS){1'b0}}, window_ms});

    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign push_data = {closes, accel_z, accel_y, accel_x};

    // Window start follows the timestamp of each closing beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
        end
        else if (push && closes)
        begin
            window_start_reg <= now_ms;
        end
    end

    // A closing beat restarts the window at its own timestamp.
    a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && closes) |=> (window_start_reg == $past(now_ms)))
        else $error("window start not moved on a closing beat");

endmodule

@@ hdl/hpwr_rms.sv @@
module hpwr_rms import hpwr_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SUM_BITS-1:0]   sum,
    input  logic [COUNT_BITS-1:0] count,
    output logic                  done,
    output logic [HP_BITS-1:0]    rms
);

    localparam int STEP_W = $clog2(SUM_BITS);

    rms_state_t               state_reg;
    rms_state_t               state_next;
    logic [STEP_W-1:0]        step_reg;
    logic [SUM_BITS-1:0]      quo_reg;
    logic [COUNT_BITS-1:0]    divisor_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic [ROOT_BITS+1:0]     srem_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [COUNT_BITS:0]      rem_shift;
    logic [COUNT_BITS:0]      rem_diff;
    logic                     rem_ge;
    logic [ROOT_BITS+3:0]     srem_shift;
    logic [ROOT_BITS+3:0]     trial;
    logic [ROOT_BITS+3:0]     srem_diff;
    logic                     srem_ge;
    logic                     last_step;

    // One restoring divide step: quotient bits shift in as dividend bits shift out.
    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    // One square-root digit: two radicand bits in, one root bit out.
    assign srem_shift = {srem_reg, quo_reg[SUM_BITS-1:SUM_BITS-2]};
    assign trial      = {2'b00, root_reg, 2'b01};
    assign srem_ge    = (srem_shift >= trial);
    assign srem_diff  = srem_shift - trial;
    assign last_step  = (step_reg == '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_DIV;
                end
            end
            R_DIV:
            begin
                if (last_step)
                begin
                    state_next = R_SQRT;
                end
            end
            R_SQRT:
            begin
                if (last_step)
                begin
                    state_next = R_DONE;
                end
            end
            R_DONE:
            begin
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        done = 1'b0;
        case (state_reg)
            R_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign rms = (root_reg[ROOT_BITS-1:HP_BITS] != '0) ? RMS_MAX : root_reg[HP_BITS-1:0];

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shared shift register: dividend and quotient first, then the radicand.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    quo_reg     <= sum;
                    divisor_reg <= count;
                    rem_reg     <= '0;
                    step_reg    <= STEP_W'(SUM_BITS - 1);
                end
            end
            R_DIV:
            begin
                quo_reg <= {quo_reg[SUM_BITS-2:0], rem_ge};
                rem_reg <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
                if (last_step)
                begin
                    srem_reg <= '0;
                    root_reg <= '0;
                    step_reg <= STEP_W'(ROOT_BITS - 1);
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
            R_SQRT:
            begin
                quo_reg  <= {quo_reg[SUM_BITS-3:0], 2'b00};
                srem_reg <= srem_ge ? srem_diff[ROOT_BITS+1:0] : srem_shift[ROOT_BITS+1:0];
                root_reg <= {root_reg[ROOT_BITS-2:0], srem_ge};
                step_reg <= step_reg - 1'b1;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    // A new root is only requested while the unit is free.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == R_IDLE))
        else $error("root requested while unit busy");

endmodule

@@ hdl/hpwr_back.sv @@
module hpwr_back import hpwr_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  logic [3*SAMPLE_BITS:0] head_data,
    output logic                   pop,
    input  logic [COEFF_BITS-1:0]  filter_coeff,
    output logic                   rms_start,
    output logic [SUM_BITS-1:0]    rms_sum,
    output logic [COUNT_BITS-1:0]  rms_count,
    input  logic                   rms_done,
    input  logic [HP_BITS-1:0]     rms_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HP_BITS-1:0]     hp_x,
    output logic [HP_BITS-1:0]     hp_y,
    output logic [HP_BITS-1:0]     hp_z,
    output logic [HP_BITS-1:0]     rms_level,
    output logic                   window_done
);

    localparam int DW = ((SAMPLE_BITS > HP_BITS - 1) ? SAMPLE_BITS : HP_BITS - 1) + 2;
    localparam int PW = DW + COEFF_BITS + 1;
    localparam int QW = PW - COEFF_BITS;

    back_state_t                   state_reg;
    back_state_t                   state_next;
    logic [2:0]                    step_reg;
    logic [2:0]                    step_next;
    logic [SAMPLE_BITS-1:0]        work_s_reg [3];
    logic                          work_done_reg;
    logic [HP_BITS-1:0]            filt_reg [3];
    logic [SAMPLE_BITS-1:0]        last_reg [3];
    logic signed [PW-1:0]          prod_reg;
    logic [SQ_BITS-1:0]            sq_reg;
    logic [SUM_BITS-1:0]           sum_reg;
    logic [COUNT_BITS-1:0]         cnt_reg;
    logic [HP_BITS-1:0]            held_rms_reg;
    logic                          out_valid_reg;
    logic [HP_BITS-1:0]            hp_x_reg;
    logic [HP_BITS-1:0]            hp_y_reg;
    logic [HP_BITS-1:0]            hp_z_reg;
    logic [HP_BITS-1:0]            rms_level_reg;
    logic                          window_done_reg;

    logic [SAMPLE_BITS-1:0]        head_s [3];
    logic                          head_done;
    logic                          issue;
    logic [1:0]                    issue_ax;
    logic                          sat_en;
    logic [1:0]                    sat_ax;
    logic                          acc_en;
    logic                          slot_free;
    logic                          load_out;
    logic [SAMPLE_BITS-1:0]        cur_s;
    logic [HP_BITS-1:0]            filt_sel;
    logic [SAMPLE_BITS-1:0]        last_sel;
    logic signed [DW-1:0]          d_val;
    logic signed [COEFF_BITS:0]    coeff_s;
    logic signed [PW-1:0]          prod_val;
    logic [QW-1:0]                 q_val;
    logic [QW-HP_BITS:0]           q_top;
    logic [HP_BITS-1:0]            hp_sat;
    logic signed [SQ_BITS-1:0]     sq_val;
    logic [SUM_BITS:0]             sum_wide;
    logic [SUM_BITS-1:0]           sum_sat;

    // Queue entry fields.
    assign head_s[0] = head_data[SAMPLE_BITS-1:0];
    assign head_s[1] = head_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign head_s[2] = head_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign head_done = head_data[3*SAMPLE_BITS];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = B_FILT;
                    step_next  = 3'd1;
                end
            end
            B_FILT:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    if (work_done_reg)
                    begin
                        state_next = B_RMS;
                    end
                    else if (slot_free)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_FIN;
                    end
                end
            end
            B_RMS:
            begin
                state_next = B_WAIT;
            end
            B_WAIT:
            begin
                if (rms_done)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer. Axis 0 is issued straight from the queue head,
    // axes 1 and 2 follow; saturation and squaring read prod_reg, accumulation reads sq_reg.
    always_comb
    begin
        issue     = 1'b0;
        issue_ax  = 2'd0;
        sat_en    = 1'b0;
        acc_en    = 1'b0;
        load_out  = 1'b0;
        rms_start = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                issue = head_valid;
                pop   = head_valid;
            end
            B_FILT:
            begin
                issue    = (step_reg <= 3'd2);
                issue_ax = step_reg[1:0];
                sat_en   = (step_reg <= 3'd3);
                acc_en   = (step_reg >= 3'd2);
                load_out = (step_reg == 3'd4) && !work_done_reg && slot_free;
            end
            B_RMS:
            begin
                rms_start = 1'b1;
            end
            B_FIN:
            begin
                load_out = slot_free;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    assign sat_ax    = step_reg[1:0] - 2'd1;
    assign slot_free = !out_valid_reg || !out_stall;

    // Filter difference and coefficient product for the issued axis.
    assign cur_s    = (state_reg == B_IDLE) ? head_s[issue_ax] : work_s_reg[issue_ax];
    assign filt_sel = filt_reg[issue_ax];
    assign last_sel = last_reg[issue_ax];
    assign d_val    = $signed({{(DW-HP_BITS){filt_sel[HP_BITS-1]}}, filt_sel})
                    + $signed({{(DW-SAMPLE_BITS){cur_s[SAMPLE_BITS-1]}}, cur_s})
                    - $signed({{(DW-SAMPLE_BITS){last_sel[SAMPLE_BITS-1]}}, last_sel});
    assign coeff_s  = $signed({1'b0, filter_coeff});
    assign prod_val = d_val * coeff_s;

    // Floor shift by the Q0.16 scale, then saturation to 20 bits, then the square.
    assign q_val  = prod_reg[PW-1:COEFF_BITS];
    assign q_top  = q_val[QW-1:HP_BITS-1];
    assign hp_sat = ((&q_top) || !(|q_top)) ? q_val[HP_BITS-1:0]
                  : (q_val[QW-1] ? HP_MIN : HP_MAX);
    assign sq_val = $signed(hp_sat) * $signed(hp_sat);

    // Saturating accumulation of the squared magnitude.
    assign sum_wide = {1'b0, sum_reg} + {{(SUM_BITS+1-SQ_BITS){1'b0}}, sq_reg};
    assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    assign rms_sum   = sum_reg;
    assign rms_count = cnt_reg;

    // Sequencer and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            held_rms_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                filt_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (issue)
            begin
                last_reg[issue_ax] <= cur_s;
            end
            if (state_reg == B_IDLE && head_valid && (cnt_reg != {COUNT_BITS{1'b1}}))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (sat_en)
            begin
                filt_reg[sat_ax] <= hp_sat;
            end
            if (acc_en)
            begin
                sum_reg <= sum_sat;
            end
            if (state_reg == B_RMS)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            if (state_reg == B_WAIT && rms_done)
            begin
                held_rms_reg <= rms_value;
            end
        end
    end

    // Working copy of the item, pipeline registers and the output beat.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_s_reg[0] <= head_s[0];
            work_s_reg[1] <= head_s[1];
            work_s_reg[2] <= head_s[2];
            work_done_reg <= head_done;
        end
        if (issue)
        begin
            prod_reg <= prod_val;
        end
        if (sat_en)
        begin
            sq_reg <= $unsigned(sq_val);
        end
        if (load_out)
        begin
            hp_x_reg        <= filt_reg[0];
            hp_y_reg        <= filt_reg[1];
            hp_z_reg        <= filt_reg[2];
            rms_level_reg   <= held_rms_reg;
            window_done_reg <= work_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hp_x        = hp_x_reg;
    assign hp_y        = hp_y_reg;
    assign hp_z        = hp_z_reg;
    assign rms_level   = rms_level_reg;
    assign window_done = window_done_reg;

    // The root is only requested for a beat that closes its window.
    a_rms_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        rms_start |-> work_done_reg)
        else $error("root requested for a beat that does not close a window");

    // A closed window leaves the sum and count cleared until its beat is delivered.
    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FIN && work_done_reg) |-> (sum_reg == '0 && cnt_reg == '0))
        else $error("sum or count not cleared after window close");

endmodule

@@ hdl/accel_highpass_windowed_rms_top.sv @@
// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall   accel_x, accel_y, accel_z, now_ms
// out       source     out_valid / out_stall hp_x, hp_y, hp_z, rms_level, window_done
// cfg       sink       cfg_we                cfg_index, cfg_data
//
// In the back end one coefficient multiplier is shared by the three axes; saturation and
// squaring work from its registered product and accumulation from the registered square.
// A sample that closes a window also passes through a 64-step bit-serial divide
// followed by a 32-step square root in one shared unit.
// The front end accepts beats into a four-entry queue, so input is stalled only when the
// queue is full; a stalled output beat holds the back end only once its next result is ready.
// Reset clears control state, sums and filter history; configuration returns to its defaults.
module accel_highpass_windowed_rms_top import hpwr_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [SAMPLE_BITS-1:0]   accel_x,
    input  logic [SAMPLE_BITS-1:0]   accel_y,
    input  logic [SAMPLE_BITS-1:0]   accel_z,
    input  logic [TIME_BITS-1:0]     now_ms,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [HP_BITS-1:0]       hp_x,
    output logic [HP_BITS-1:0]       hp_y,
    output logic [HP_BITS-1:0]       hp_z,
    output logic [HP_BITS-1:0]       rms_level,
    output logic                     window_done
);

    localparam int ENTRY_BITS = 3 * SAMPLE_BITS + 1;

    logic [COEFF_BITS-1:0] coeff_reg;
    logic [WIN_BITS-1:0]   window_reg;
    logic                  q_full;
    logic                  q_push;
    logic [ENTRY_BITS-1:0] q_push_data;
    logic                  q_pop;
    logic                  q_head_valid;
    logic [ENTRY_BITS-1:0] q_head_data;
    logic                  rms_start;
    logic [SUM_BITS-1:0]   rms_sum;
    logic [COUNT_BITS-1:0] rms_count;
    logic                  rms_done;
    logic [HP_BITS-1:0]    rms_value;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg  <= COEFF_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_COEFF:
                begin
                    coeff_reg <= cfg_data[COEFF_BITS-1:0];
                end
                CFG_WINDOW_MS:
                begin
                    window_reg <= cfg_data[WIN_BITS-1:0];
                end
                default:
                begin
                    coeff_reg <= coeff_reg;
                end
            endcase
        end
    end

    // Front end: accepts beats and marks those that close a window.
    hpwr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .now_ms    (now_ms),
        .window_ms (window_reg),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Queue between the two halves.
    hpwr_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    // Back end: filters, accumulates and delivers results.
    hpwr_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_head_valid),
        .head_data    (q_head_data),
        .pop          (q_pop),
        .filter_coeff (coeff_reg),
        .rms_start    (rms_start),
        .rms_sum      (rms_sum),
        .rms_count    (rms_count),
        .rms_done     (rms_done),
        .rms_value    (rms_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hp_x         (hp_x),
        .hp_y         (hp_y),
        .hp_z         (hp_z),
        .rms_level    (rms_level),
        .window_done  (window_done)
    );

    // Mean and square root at window close.
    hpwr_rms #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rms (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rms_start),
        .sum   (rms_sum),
        .count (rms_count),
        .done  (rms_done),
        .rms   (rms_value)
    );

endmodule
